// File: rtl/xeu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xeu_pkg
// Types and constants of the XML entity unescaper: entity table, widths,
// and the result list that moves from the decoder to the result queue.
// ----------------------------------------------------------------------------
package xeu_pkg;

    localparam int CAP_W          = 17;
    localparam int CNT_W          = 3;
    localparam int MAX_ENTITY_LEN = 6;
    localparam int PEND_DEPTH     = MAX_ENTITY_LEN - 1;
    localparam int NUM_ENT        = 5;
    localparam int RES_DEPTH      = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = 17'd4096;
    localparam logic [7:0]       AMP_CHAR  = 8'h26;

    typedef logic [7:0] t_byte;

    // Entity text, zero padded to the longest entity
    localparam t_byte ENT_TEXT [NUM_ENT][MAX_ENTITY_LEN] = '{
        '{8'h26, 8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00},   // &amp;
        '{8'h26, 8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00},   // &lt;
        '{8'h26, 8'h67, 8'h74, 8'h3b, 8'h00, 8'h00},   // &gt;
        '{8'h26, 8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b},   // &quot;
        '{8'h26, 8'h61, 8'h70, 8'h6f, 8'h73, 8'h3b}    // &apos;
    };

    localparam logic [CNT_W-1:0] ENT_LEN [NUM_ENT] = '{3'd5, 3'd4, 3'd4, 3'd6, 3'd6};

    localparam t_byte ENT_DEC [NUM_ENT] = '{8'h26, 8'h3c, 8'h3e, 8'h22, 8'h27};

    // Results caused by one item: cnt entries, the last one is the
    // terminator when term is set (its byte is zero).
    typedef struct packed {
        logic [CNT_W-1:0]            cnt;
        logic                        term;
        logic [RES_DEPTH-1:0][7:0]   bytes;
    } t_res;

endpackage

// File: rtl/xml_entity_unescaper_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_entity_unescaper_unit
// Streaming decoder of the five predefined XML entities with a per-string
// output capacity limit and a terminator item at end of string.
// ----------------------------------------------------------------------------
// An accepted item is held in the input register, is decoded in one
// pass into its full list of results (up to seven) and loaded into the
// result queue, which hands out one result per cycle while the output
// is ready; the first result is valid once its list is in the queue.
// The next item is decoded in the cycle the last result is taken, so
// text without entity failures flows at one item per cycle while the
// output is ready. Items that cause no result do not hold the queue.
// Capacity is written through the configuration channel, which is
// always ready.
// ----------------------------------------------------------------------------
module xml_entity_unescaper_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [xeu_pkg::CAP_W-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  xeu_pkg::t_byte            i_in_byte,
    input  logic                      i_is_last,
    input  logic                      i_no_byte,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output xeu_pkg::t_byte            o_out_byte,
    output logic                      o_terminator,
    output logic                      o_run_last
);
    import xeu_pkg::*;

    logic [CAP_W-1:0]  r_cap;
    logic              r_in_valid;
    t_byte             r_in_byte;
    logic              r_is_last;
    logic              r_no_byte;

    logic              can_load;
    logic              step;
    t_res              res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_valid) begin
            r_cap <= i_cfg_data;
        end
    end

    assign step       = r_in_valid && can_load;
    assign o_in_ready = !r_in_valid || can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_in_byte;
            r_is_last <= i_is_last;
            r_no_byte <= i_no_byte;
        end
    end

    xeu_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_byte    (r_in_byte),
        .i_last    (r_is_last),
        .i_no_byte (r_no_byte),
        .i_cap     (r_cap),
        .o_res     (res)
    );

    xeu_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (step),
        .i_res      (res),
        .o_can_load (can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_byte     (o_out_byte),
        .o_term     (o_terminator),
        .o_run_last (o_run_last)
    );

endmodule

// File: rtl/xeu_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xeu_core
// Per-item decode: entity prefix match, lookahead buffer, capacity limit.
// Builds the full result list of one item combinationally.
// ----------------------------------------------------------------------------
module xeu_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  xeu_pkg::t_byte         i_byte,
    input  logic                   i_last,
    input  logic                   i_no_byte,
    input  logic [xeu_pkg::CAP_W-1:0] i_cap,
    output xeu_pkg::t_res          o_res
);
    import xeu_pkg::*;

    t_byte              r_pend [PEND_DEPTH];
    logic [CNT_W-1:0]   r_pcnt;
    logic [CAP_W-1:0]   r_emitted;
    logic               r_reached;

    logic [CNT_W-1:0]   n_pcnt;
    logic [CAP_W-1:0]   n_emitted;
    logic               n_reached;

    logic [CAP_W:0]     room_diff;
    logic [CNT_W-1:0]   avail;
    t_byte              cand [MAX_ENTITY_LEN];
    logic [CNT_W-1:0]   total;
    logic               is_match;
    logic               is_prefix;
    t_byte              dec;
    logic               is_amp;
    logic [CNT_W-1:0]   alen;
    logic [CNT_W-1:0]   nbytes;
    logic               open_buf;
    logic               append;
    logic               overflow;

    // bytes still allowed in this string, saturated
    assign room_diff = {1'b0, i_cap} - {1'b0, r_emitted} - {{CAP_W{1'b0}}, 1'b1};

    always_comb begin
        if (r_reached || room_diff[CAP_W]) begin
            avail = '0;
        end else if (|room_diff[CAP_W-1:CNT_W]) begin
            avail = '1;
        end else begin
            avail = room_diff[CNT_W-1:0];
        end
    end

    // candidate = pending bytes followed by the new byte
    always_comb begin
        for (int j = 0; j < MAX_ENTITY_LEN; j++) begin
            cand[j] = 8'h00;
        end
        for (int j = 0; j < PEND_DEPTH; j++) begin
            if (CNT_W'(j) < r_pcnt) begin
                cand[j] = r_pend[j];
            end
        end
        for (int j = 0; j < MAX_ENTITY_LEN; j++) begin
            if (CNT_W'(j) == r_pcnt) begin
                cand[j] = i_byte;
            end
        end
    end

    assign total = r_pcnt + CNT_W'(1);

    always_comb begin
        logic ok;
        is_match  = 1'b0;
        is_prefix = 1'b0;
        dec       = 8'h00;
        for (int k = 0; k < NUM_ENT; k++) begin
            ok = (total <= ENT_LEN[k]);
            for (int j = 0; j < MAX_ENTITY_LEN; j++) begin
                if (CNT_W'(j) < total && cand[j] != ENT_TEXT[k][j]) begin
                    ok = 1'b0;
                end
            end
            if (ok && total == ENT_LEN[k]) begin
                is_match = 1'b1;
                dec      = dec | ENT_DEC[k];
            end else if (ok) begin
                is_prefix = 1'b1;
            end
        end
    end

    assign is_amp = (i_byte == AMP_CHAR);

    // alen: bytes this item would emit before the capacity limit
    always_comb begin
        alen     = '0;
        open_buf = 1'b0;
        append   = 1'b0;
        if (i_no_byte) begin
            alen = i_last ? r_pcnt : '0;
        end else if (r_pcnt == '0) begin
            alen     = (!is_amp || i_last) ? CNT_W'(1) : '0;
            open_buf = is_amp;
        end else if (is_match) begin
            alen = CNT_W'(1);
        end else if (is_prefix) begin
            alen   = i_last ? total : '0;
            append = 1'b1;
        end else begin
            // failed prefix: flush literally, rescan the new byte
            alen     = (!is_amp || i_last) ? total : r_pcnt;
            open_buf = is_amp;
        end
    end

    assign nbytes   = (alen < avail) ? alen : avail;
    assign overflow = !i_no_byte && (avail == '0 || alen > avail);

    always_comb begin
        o_res       = '0;
        o_res.cnt   = nbytes + CNT_W'(i_last);
        o_res.term  = i_last;
        for (int i = 0; i < MAX_ENTITY_LEN; i++) begin
            if (CNT_W'(i) < nbytes) begin
                o_res.bytes[i] = (is_match && !i_no_byte && r_pcnt != '0) ? dec : cand[i];
            end
        end
    end

    always_comb begin
        n_pcnt    = r_pcnt;
        n_emitted = r_emitted;
        n_reached = r_reached;
        if (i_last) begin
            n_pcnt    = '0;
            n_emitted = '0;
            n_reached = 1'b0;
        end else if (!i_no_byte) begin
            n_emitted = r_emitted + CAP_W'(nbytes);
            n_reached = r_reached | overflow;
            if (overflow) begin
                n_pcnt = '0;
            end else if (open_buf) begin
                n_pcnt = CNT_W'(1);
            end else if (append) begin
                n_pcnt = total;
            end else begin
                n_pcnt = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcnt    <= '0;
            r_emitted <= '0;
            r_reached <= 1'b0;
        end else if (i_step) begin
            r_pcnt    <= n_pcnt;
            r_emitted <= n_emitted;
            r_reached <= n_reached;
        end
    end

    // lookahead buffer, written only where a byte is added
    always_ff @(posedge i_clk) begin
        if (i_step && !i_last && !i_no_byte && !overflow) begin
            for (int j = 0; j < PEND_DEPTH; j++) begin
                if ((open_buf && j == 0) || (append && CNT_W'(j) == r_pcnt)) begin
                    r_pend[j] <= i_byte;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_pcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcnt <= CNT_W'(PEND_DEPTH))
        else $error("lookahead count out of range");

    a_buf_starts_amp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcnt != '0 |-> r_pend[0] == AMP_CHAR)
        else $error("lookahead buffer does not start with ampersand");

    a_string_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_last |=> (r_pcnt == '0 && r_emitted == '0 && !r_reached))
        else $error("string state not cleared after end of string");
`endif

endmodule

// File: rtl/xeu_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xeu_outq
// Result queue: holds the result list of one item and hands it out one
// result per cycle while the output is ready; reloads when empty or in the cycle its last result is taken.
// ----------------------------------------------------------------------------
module xeu_outq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  xeu_pkg::t_res   i_res,
    output logic            o_can_load,
    output logic            o_valid,
    input  logic            i_ready,
    output xeu_pkg::t_byte  o_byte,
    output logic            o_term,
    output logic            o_run_last
);
    import xeu_pkg::*;

    logic [CNT_W-1:0]           r_cnt;
    logic                       r_term;
    logic [RES_DEPTH-1:0][7:0]  r_bytes;

    logic [CNT_W-1:0]           n_cnt;
    logic                       n_term;
    logic [RES_DEPTH-1:0][7:0]  n_bytes;
    logic                       pop;

    assign pop        = (r_cnt != '0) && i_ready;
    assign o_can_load = (r_cnt == '0) || (r_cnt == CNT_W'(1) && i_ready);

    always_comb begin
        n_cnt   = r_cnt;
        n_term  = r_term;
        n_bytes = r_bytes;
        if (i_load) begin
            n_cnt   = i_res.cnt;
            n_term  = i_res.term;
            n_bytes = i_res.bytes;
        end else if (pop) begin
            n_cnt   = r_cnt - CNT_W'(1);
            n_bytes = {8'h00, r_bytes[RES_DEPTH-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_term <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_term <= n_term;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
    end

    assign o_valid    = (r_cnt != '0);
    assign o_byte     = r_bytes[0];
    assign o_run_last = (r_cnt == CNT_W'(1));
    assign o_term     = r_term && (r_cnt == CNT_W'(1));

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (r_cnt == '0 || (r_cnt == CNT_W'(1) && i_ready)))
        else $error("result list loaded over pending results");

    a_pop_decrements: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt > CNT_W'(1) && i_ready && !i_load) |=> r_cnt == $past(r_cnt) - CNT_W'(1))
        else $error("result count did not step down on pop");

    a_term_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && i_res.term) |-> i_res.cnt != '0)
        else $error("terminator list loaded with zero count");
`endif

endmodule
